// ===== design/pcd_pkg.sv =====
// Shared types and constants for the prefix code decoder.
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

  localparam int TableEntries = 256;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int MaxCodeLen   = 16;
  localparam int CodeW        = 16;
  localparam int LenW         = 5;
  localparam int ValW         = 8;
  localparam int ByteBits     = 8;
  localparam int NbitsW       = 4;

  localparam logic [ValW-1:0]   ValueBias   = 8'd128;
  localparam logic [NbitsW-1:0] ByteBitsCnt = 4'd8;

  typedef enum logic [0:0] {
    CmdLoad   = 1'b0,
    CmdDecode = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StShift,
    StSearch,
    StPush,
    StFinish
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [IdxW-1:0]   entry_index;
    logic [CodeW-1:0]  code_bits;
    logic [LenW-1:0]   code_length;
    logic [ValW-1:0]   stored_value;
    logic [ByteBits-1:0] data_byte;
    logic [NbitsW-1:0] valid_bits;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] out_byte;
    logic            overflow_error;
    logic            last_of_run;
  } out_item_t;

  // One table slot as held in the table memory.
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
    logic [ValW-1:0]  value;
  } entry_t;

  // Running prefix handed to the compare unit.
  typedef struct packed {
    logic [CodeW-1:0] bits;
    logic [LenW-1:0]  len;
  } prefix_t;

endpackage

`default_nettype wire

// ===== design/pcd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/pcd_match.sv =====
// Compare unit: checks one table slot against the running prefix.
`timescale 1ns / 1ps
`default_nettype none

module pcd_match
  import pcd_pkg::*;
(
  input  wire entry_t  entry_i,
  input  wire prefix_t prefix_i,
  output logic         hit_o
);

  logic [CodeW-1:0] mask;

  always_comb begin
    for (int i = 0; i < CodeW; i++) begin
      mask[i] = (LenW'(i) < prefix_i.len);
    end
  end

  // Code bits above the prefix length do not take part in the compare.
  assign hit_o = (entry_i.len == prefix_i.len) &&
                 (((entry_i.code ^ prefix_i.bits) & mask) == '0);

endmodule

`default_nettype wire

// ===== design/prefix_code_decoder_core.sv =====
// Top level of the prefix code decoder: sequencer, table and output register.
//
// Input channel (in_valid_i, in_stall_o, in_item_i): a load beat writes one
// table slot. A decode beat carries one compressed byte; its bits are consumed
// MSB first, and for each bit the compare unit walks the table memory one slot
// per cycle, lowest index first, stopping at the first match. A bit takes at
// most a shift step, a memory read per slot, the read latency, and a step to
// leave the search or to hand off a symbol; output stalls add to this. in_stall_o
// stays high from the decode beat until its last result sits in the output
// register.
// Output channel (out_valid_o, out_stall_i, out_item_o): one beat per decoded
// symbol or prefix overflow. The most recent result is held back internally
// until the next one appears or the byte ends, so last_of_run is known when
// the beat is presented. While the receiver stalls, the output register
// holds its beat and the sequencer waits in its hand-off step.
// Reset clears the slot valid flags (all slots empty), the prefix, and all
// control state; table contents need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module prefix_code_decoder_core
  import pcd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  state_e              state_q, state_d;
  logic [ByteBits-1:0] byte_q, byte_d;
  logic [NbitsW-1:0]   nbits_q, nbits_d;
  logic [NbitsW-1:0]   bitcnt_q, bitcnt_d;
  logic                eos_q, eos_d;
  prefix_t             prefix_q, prefix_d;
  logic [IdxW:0]       scan_q, scan_d;
  logic                chk_q, chk_d;
  logic                vbit_q, vbit_d;
  logic [ValW-1:0]     new_byte_q, new_byte_d;
  logic                new_err_q, new_err_d;
  logic                pend_q, pend_d;
  logic [ValW-1:0]     pend_byte_q, pend_byte_d;
  logic                pend_err_q, pend_err_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic [TableEntries-1:0] slot_valid_q;

  logic            load_beat;
  logic            decode_beat;
  logic            issue;
  logic            bits_done;
  logic [LenW-1:0] len_next;
  logic            overflow;
  logic            cmp_hit;
  logic            hit;
  logic            out_free;
  entry_t          wr_entry;
  entry_t          rd_entry;

  assign load_beat   = (state_q == StIdle) && in_valid_i && (in_item_i.command == CmdLoad);
  assign decode_beat = (state_q == StIdle) && in_valid_i && (in_item_i.command == CmdDecode);
  assign issue       = (state_q == StSearch) && !scan_q[IdxW];
  assign bits_done   = (bitcnt_q == nbits_q);
  assign len_next    = prefix_q.len + LenW'(1);
  assign overflow    = (len_next > LenW'(MaxCodeLen));
  assign hit         = chk_q && vbit_q && cmp_hit;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign wr_entry.code  = in_item_i.code_bits;
  assign wr_entry.len   = in_item_i.code_length;
  assign wr_entry.value = in_item_i.stored_value;

  pcd_ram #(
    .Width($bits(entry_t)),
    .Depth(TableEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (load_beat),
    .waddr_i(in_item_i.entry_index),
    .wdata_i(wr_entry),
    .re_i   (issue),
    .raddr_i(scan_q[IdxW-1:0]),
    .rdata_o(rd_entry)
  );

  pcd_match u_match (
    .entry_i (rd_entry),
    .prefix_i(prefix_q),
    .hit_o   (cmp_hit)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (decode_beat) begin
          state_d = StShift;
        end
      end
      StShift: begin
        if (bits_done) begin
          state_d = StFinish;
        end else if (overflow) begin
          state_d = StPush;
        end else begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (hit) begin
          state_d = StPush;
        end else if (!chk_q && !issue) begin
          state_d = StShift;
        end
      end
      StPush: begin
        if (!pend_q || out_free) begin
          state_d = StShift;
        end
      end
      StFinish: begin
        if (!pend_q || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    byte_d      = byte_q;
    nbits_d     = nbits_q;
    bitcnt_d    = bitcnt_q;
    eos_d       = eos_q;
    prefix_d    = prefix_q;
    scan_d      = scan_q;
    chk_d       = 1'b0;
    vbit_d      = vbit_q;
    new_byte_d  = new_byte_q;
    new_err_d   = new_err_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    pend_err_d  = pend_err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      StIdle: begin
        if (decode_beat) begin
          byte_d   = in_item_i.data_byte;
          nbits_d  = (in_item_i.valid_bits > ByteBitsCnt) ? ByteBitsCnt
                                                          : in_item_i.valid_bits;
          bitcnt_d = '0;
          eos_d    = in_item_i.end_of_stream;
        end
      end
      StShift: begin
        if (bits_done) begin
          if (eos_q) begin
            prefix_d = '0;
          end
        end else begin
          byte_d   = {byte_q[ByteBits-2:0], 1'b0};
          bitcnt_d = bitcnt_q + NbitsW'(1);
          if (overflow) begin
            prefix_d   = '0;
            new_byte_d = '0;
            new_err_d  = 1'b1;
          end else begin
            prefix_d.bits = {prefix_q.bits[CodeW-2:0], byte_q[ByteBits-1]};
            prefix_d.len  = len_next;
            scan_d        = '0;
          end
        end
      end
      StSearch: begin
        // The memory read issued in one cycle is compared in the next.
        chk_d  = issue;
        vbit_d = slot_valid_q[scan_q[IdxW-1:0]];
        scan_d = scan_q + (IdxW+1)'(issue);
        if (hit) begin
          chk_d      = 1'b0;
          prefix_d   = '0;
          new_byte_d = rd_entry.value - ValueBias;
          new_err_d  = 1'b0;
        end
      end
      StPush: begin
        if (!pend_q || out_free) begin
          if (pend_q) begin
            out_valid_d          = 1'b1;
            out_d.out_byte       = pend_byte_q;
            out_d.overflow_error = pend_err_q;
            out_d.last_of_run    = 1'b0;
          end
          pend_d      = 1'b1;
          pend_byte_d = new_byte_q;
          pend_err_d  = new_err_q;
        end
      end
      StFinish: begin
        if (pend_q && out_free) begin
          out_valid_d          = 1'b1;
          out_d.out_byte       = pend_byte_q;
          out_d.overflow_error = pend_err_q;
          out_d.last_of_run    = 1'b1;
          pend_d               = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      prefix_q     <= '0;
      chk_q        <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      slot_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      chk_q       <= chk_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (load_beat) begin
        slot_valid_q[in_item_i.entry_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    nbits_q     <= nbits_d;
    bitcnt_q    <= bitcnt_d;
    eos_q       <= eos_d;
    scan_q      <= scan_d;
    vbit_q      <= vbit_d;
    new_byte_q  <= new_byte_d;
    new_err_q   <= new_err_d;
    pend_byte_q <= pend_byte_d;
    pend_err_q  <= pend_err_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // No result may be held back once the block takes new beats again.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !pend_q)
    else $error("pending result left over while idle");

  // The prefix never grows past the longest code.
  a_prefix_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_q.len <= LenW'(MaxCodeLen))
    else $error("prefix longer than the maximum code length");

  // A table compare is only live during the search.
  a_chk_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (state_q == StSearch))
    else $error("table compare outside the search");

  // An overflow beat carries a zero byte.
  a_overflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.overflow_error) |-> (out_q.out_byte == '0))
    else $error("overflow beat with nonzero byte");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the prefix code decoder: code tables, encoded bit streams and prefix overflows.
`timescale 1ns / 1ps

module tb_top;
  import pcd_pkg::*;

  localparam int ItemTarget = 250;
  localparam int QuietLimit = 20000;
  localparam int TailCycles = 2500;
  localparam int MaxLeaves  = 17;

  typedef struct packed {
    logic     hold;
    in_item_t item;
  } feed_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  feed_t     feed_q[$];
  out_item_t symbol_q[$];
  bit        hold_next;
  bit        drained;
  out_item_t want_item;
  int        sent_cnt;
  int        quiet_cycles;
  int        err_cnt;
  int        got_cnt;
  int        ovf_cnt;
  int        load_cnt;
  int        byte_cnt;

  // Mirror of the decoder state.
  logic [CodeW-1:0] tbl_code [TableEntries];
  logic [LenW-1:0]  tbl_len  [TableEntries];
  logic [ValW-1:0]  tbl_val  [TableEntries];
  logic [CodeW-1:0] run_bits;
  int               run_len;

  wire calm = (sent_cnt >= 90) && (sent_cnt < 150);

  prefix_code_decoder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic add_load(input logic [IdxW-1:0] idx, input logic [CodeW-1:0] code,
                          input logic [LenW-1:0] len, input logic [ValW-1:0] val);
    feed_t f;
    f.hold              = 1'b0;
    f.item.command      = CmdLoad;
    f.item.entry_index  = idx;
    f.item.code_bits    = code;
    f.item.code_length  = len;
    f.item.stored_value = val;
    f.item.data_byte    = 8'($urandom);
    f.item.valid_bits   = 4'($urandom);
    f.item.end_of_stream = 1'($urandom);
    feed_q.push_back(f);
  endtask

  task automatic add_byte(input logic [ByteBits-1:0] data, input logic [NbitsW-1:0] nbits,
                          input logic eos);
    feed_t f;
    f.hold              = hold_next;
    f.item.command      = CmdDecode;
    f.item.entry_index  = 8'($urandom);
    f.item.code_bits    = 16'($urandom);
    f.item.code_length  = 5'($urandom);
    f.item.stored_value = 8'($urandom);
    f.item.data_byte    = data;
    f.item.valid_bits   = nbits;
    f.item.end_of_stream = eos;
    hold_next = 1'b0;
    feed_q.push_back(f);
  endtask

  // Walks the beat's bits through the mirrored prefix and queues the symbols it yields.
  task automatic predict_symbols(input in_item_t beat);
    out_item_t        run [ByteBits];
    logic [CodeW:0]   mask;
    int               n_bits;
    int               n_out;
    int               hit;
    if (beat.command == CmdLoad) begin
      tbl_code[beat.entry_index] = beat.code_bits;
      tbl_len[beat.entry_index]  = beat.code_length;
      tbl_val[beat.entry_index]  = beat.stored_value;
      load_cnt++;
    end else begin
      byte_cnt++;
      n_bits = (beat.valid_bits > ByteBitsCnt) ? ByteBits : int'(beat.valid_bits);
      n_out  = 0;
      for (int b = 0; b < n_bits; b++) begin
        run_bits = {run_bits[CodeW-2:0], beat.data_byte[ByteBits-1-b]};
        run_len++;
        if (run_len > MaxCodeLen) begin
          run[n_out].out_byte       = '0;
          run[n_out].overflow_error = 1'b1;
          run[n_out].last_of_run    = 1'b0;
          n_out++;
          run_bits = '0;
          run_len  = 0;
        end else begin
          mask = (17'd1 << run_len) - 17'd1;
          hit  = -1;
          for (int s = 0; s < TableEntries && hit < 0; s++) begin
            if (int'(tbl_len[s]) == run_len &&
                ((tbl_code[s] ^ run_bits) & mask[CodeW-1:0]) == '0) begin
              hit = s;
            end
          end
          if (hit >= 0) begin
            run[n_out].out_byte       = tbl_val[hit] - ValueBias;
            run[n_out].overflow_error = 1'b0;
            run[n_out].last_of_run    = 1'b0;
            n_out++;
            run_bits = '0;
            run_len  = 0;
          end
        end
      end
      if (beat.end_of_stream) begin
        run_bits = '0;
        run_len  = 0;
      end
      if (n_out > 0) begin
        run[n_out-1].last_of_run = 1'b1;
      end
      for (int k = 0; k < n_out; k++) begin
        symbol_q.push_back(run[k]);
      end
    end
  endtask

  // Sender. A beat marked hold waits until every expected symbol has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      sent_cnt   <= 0;
    end else if (in_valid_i && in_stall_o) begin
      // A stalled beat stays on the bus unchanged.
    end else begin
      if (in_valid_i) begin
        void'(feed_q.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (feed_q.size() != 0 && (calm || $urandom_range(99, 0) >= 24) &&
          (!feed_q[0].hold || (drained && !in_valid_i))) begin
        in_valid_i <= 1'b1;
        in_item_i  <= feed_q[0].item;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99, 0) < 24);
    end
  end

  // Checks each output beat against the oldest expected symbol, then predicts new ones.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (tbl_len[s]) tbl_len[s] = '0;
      run_bits = '0;
      run_len  = 0;
      drained <= 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_cnt++;
        if (out_item_o.overflow_error === 1'b1) ovf_cnt++;
        if (symbol_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("Result %0d: byte %02h ovf %0b last %0b arrived with nothing expected",
                     got_cnt, out_item_o.out_byte, out_item_o.overflow_error,
                     out_item_o.last_of_run);
          end
        end else begin
          want_item = symbol_q.pop_front();
          if (out_item_o.out_byte !== want_item.out_byte ||
              out_item_o.overflow_error !== want_item.overflow_error ||
              out_item_o.last_of_run !== want_item.last_of_run) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("Result %0d: expected byte %02h ovf %0b last %0b, got byte %02h ovf %0b last %0b",
                       got_cnt, want_item.out_byte, want_item.overflow_error,
                       want_item.last_of_run, out_item_o.out_byte,
                       out_item_o.overflow_error, out_item_o.last_of_run);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_symbols(in_item_i);
      end
      drained <= (symbol_q.size() == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no beat accepted for %0d cycles", QuietLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int               n_sym;
    int               n_leaf;
    int               pick;
    int               slot;
    int               take;
    int               nb;
    int               n_in;
    int               drop;
    int               j;
    bit               deep;
    bit               open_end;
    bit               used [TableEntries];
    bit               bits_q[$];
    int               live_slot[$];
    logic [ByteBits-1:0] data;
    logic [CodeW:0]   mask;
    logic [CodeW-1:0] leaf_code [MaxLeaves];
    int               leaf_len  [MaxLeaves];
    int               leaf_slot [MaxLeaves];

    // Directed part. Slot 0 carries junk above its one-bit code, slot 2 repeats
    // slot 1's code and must lose, slot 3 is too long to ever match.
    add_load(8'd0,   16'hFFFE, 5'd1,  8'h00);
    add_load(8'd1,   16'h0002, 5'd2,  8'hFF);
    add_load(8'd2,   16'hFFF6, 5'd2,  8'h01);
    add_load(8'd3,   16'h0000, 5'd31, 8'h55);
    add_load(8'd4,   16'h0001, 5'd0,  8'hAA);
    add_load(8'd255, 16'hFFFF, 5'd16, 8'h80);
    hold_next = 1'b1;
    add_byte(8'h00, 4'd8,  1'b0);
    add_byte(8'hAA, 4'd15, 1'b0);
    add_byte(8'hFF, 4'd8,  1'b0);
    add_byte(8'hFF, 4'd8,  1'b0);
    add_byte(8'hC0, 4'd8,  1'b0);
    add_byte(8'h00, 4'd8,  1'b0);
    add_byte(8'h7F, 4'd1,  1'b0);
    add_byte(8'hC0, 4'd2,  1'b0);
    add_byte(8'hFF, 4'd0,  1'b1);
    add_byte(8'h5F, 4'd2,  1'b0);
    add_byte(8'hE0, 4'd3,  1'b1);
    add_byte(8'h8F, 4'd2,  1'b1);

    // Random part: build a prefix-free code by splitting leaves, load it over the
    // previous table, then send encoded streams with some noise mixed in.
    live_slot = {0, 1, 2, 3, 255};
    while (feed_q.size() < ItemTarget) begin
      n_sym = $urandom_range(MaxLeaves, 2);
      deep  = 1'($urandom);
      leaf_code[0] = '0;
      leaf_len[0]  = 0;
      n_leaf       = 1;
      // Depth never exceeds n_leaf - 1, so codes stay within sixteen bits.
      while (n_leaf < n_sym) begin
        pick = (deep && $urandom_range(3, 0) != 0) ? n_leaf - 1 : $urandom_range(n_leaf - 1, 0);
        leaf_code[n_leaf] = {leaf_code[pick][CodeW-2:0], 1'b1};
        leaf_code[pick]   = {leaf_code[pick][CodeW-2:0], 1'b0};
        leaf_len[n_leaf]  = leaf_len[pick] + 1;
        leaf_len[pick]++;
        n_leaf++;
      end

      foreach (used[s]) used[s] = 1'b0;
      foreach (live_slot[s]) used[live_slot[s]] = 1'b1;
      for (int i = 0; i < n_leaf; i++) begin
        if (i < live_slot.size()) begin
          leaf_slot[i] = live_slot[i];
        end else begin
          do slot = $urandom_range(TableEntries - 1, 0); while (used[slot]);
          used[slot]   = 1'b1;
          leaf_slot[i] = slot;
        end
      end
      for (int i = n_leaf; i < live_slot.size(); i++) begin
        add_load(8'(live_slot[i]), 16'($urandom), 5'd0, 8'($urandom));
      end

      // Now and then one code is left out of the table, so its bits run into overflow.
      drop = ($urandom_range(9, 0) == 0) ? $urandom_range(n_leaf - 1, 0) : -1;
      live_slot = {};
      for (int i = 0; i < n_leaf; i++) begin
        mask = (17'd1 << leaf_len[i]) - 17'd1;
        add_load(8'(leaf_slot[i]), (16'($urandom) & ~mask[CodeW-1:0]) | leaf_code[i],
                 (i == drop) ? 5'd0 : 5'(leaf_len[i]), 8'($urandom));
        live_slot.push_back(leaf_slot[i]);
      end
      if ($urandom_range(3, 0) == 0) begin
        j = $urandom_range(n_leaf - 1, 0);
        do slot = $urandom_range(TableEntries - 1, 0); while (used[slot]);
        used[slot] = 1'b1;
        add_load(8'(slot), leaf_code[j], 5'(leaf_len[j]), 8'($urandom));
        live_slot.push_back(slot);
      end

      hold_next = 1'b1;
      repeat ($urandom_range(4, 2)) begin
        bits_q = {};
        n_in   = $urandom_range(12, 1);
        repeat (n_in) begin
          j = $urandom_range(n_leaf - 1, 0);
          for (int b = leaf_len[j] - 1; b >= 0; b--) bits_q.push_back(leaf_code[j][b]);
        end
        open_end = ($urandom_range(9, 0) == 0);
        while (bits_q.size() != 0) begin
          take = (bits_q.size() > ByteBits) ? ByteBits : bits_q.size();
          data = 8'($urandom);
          for (int b = 0; b < take; b++) data[ByteBits-1-b] = bits_q.pop_front();
          nb = take;
          if (take == ByteBits && $urandom_range(4, 0) == 0) nb = $urandom_range(15, 9);
          add_byte(data, 4'(nb), (bits_q.size() == 0) && !open_end);
        end
        if ($urandom_range(5, 0) == 0) begin
          if ($urandom_range(1, 0) == 0) begin
            add_byte(8'($urandom), 4'($urandom), 1'($urandom));
          end else begin
            add_load(8'(live_slot[$urandom_range(live_slot.size() - 1, 0)]), 16'($urandom),
                     5'($urandom), 8'($urandom));
          end
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (symbol_q.size() != 0) @(posedge clk_i);
    // A trailing beat may still be searching the table without producing a symbol.
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d table loads and %0d data bytes; checked %0d output beats, %0d overflows.",
             load_cnt, byte_cnt, got_cnt, ovf_cnt);
    $display("Result errors counted: %0d", err_cnt);
    if (err_cnt == 0 && symbol_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
